FILE: sv/tspes_pkg.sv
package tspes_pkg;

	localparam int PID_BITS = 13;
	localparam int PID_SPACE = 8192;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_UPDATED = 2'd1,
		ST_FULL = 2'd2,
		ST_UNMAPPED = 2'd3
	} status_t;

	typedef struct packed {
		logic clr_start;
		logic clr_step;
		logic load;
		logic prog_step;
		logic prog_commit;
		logic map_read;
		logic es_start;
		logic es_step;
		logic es_commit;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_es;
		logic prog_done;
		logic map_ok;
		logic es_done;
	} sts_t;

endpackage

FILE: sv/ts_program_es_table_core.sv
// Transport-stream program table with per-program elementary stream lists.
// Input channel: in_valid/in_stall with req_type, prog_num, pmt_pid,
// es_pid, strm_type. Output channel: out_valid/out_stall with status,
// pid_mapped, program_index, es_index. One result per request.
// One request at a time; in_stall stays high until the result is taken.
// Program request: linear search of the program slots, one slot per cycle,
// then a commit step. ES request: PID map read, then, if the PMT PID is
// mapped, ES search in which each entry is first read from the store and
// then compared, then commit; an unmapped PID skips search and commit.
// The ES store has a single read port, which sets the search pace.
// The next request can be accepted in the cycle after the result transfer.
// After reset a sweep clears all 8192 PID map entries; in_stall is high
// until it ends. A stalled result holds on the output ports and the block
// accepts nothing new until it is transferred.
module ts_program_es_table_core #(
	parameter int MAX_PROGRAMS = 16,
	parameter int MAX_STREAMS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic req_type,
	input logic [15:0] prog_num,
	input logic [15:0] pmt_pid,
	input logic [15:0] es_pid,
	input logic [7:0] strm_type,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] status,
	output logic pid_mapped,
	output logic [3:0] program_index,
	output logic [3:0] es_index
);

	tspes_pkg::cmd_t cmd;
	tspes_pkg::sts_t sts;

	tspes_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
	);

	tspes_dp #(.MAX_PROGRAMS(MAX_PROGRAMS), .MAX_STREAMS(MAX_STREAMS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_type(req_type), .prog_num(prog_num), .pmt_pid(pmt_pid),
		.es_pid(es_pid), .strm_type(strm_type), .status(status),
		.pid_mapped(pid_mapped), .program_index(program_index), .es_index(es_index)
	);

endmodule

FILE: sv/tspes_ctrl.sv
module tspes_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	output tspes_pkg::cmd_t cmd,
	input tspes_pkg::sts_t sts
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_PSRCH, S_PCOMMIT, S_MREAD, S_MWAIT,
		S_ESRCH, S_ECOMMIT, S_OUT
	} state_t;

	state_t state_q;
	logic clr_started_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_start = !clr_started_q;
				cmd.clr_step = clr_started_q;
			end
			S_IDLE: cmd.load = in_valid;
			S_PSRCH: cmd.prog_step = 1'b1;
			S_PCOMMIT: cmd.prog_commit = 1'b1;
			S_MREAD: cmd.map_read = 1'b1;
			S_MWAIT: cmd.es_start = 1'b1;
			S_ESRCH: cmd.es_step = 1'b1;
			S_ECOMMIT: cmd.es_commit = 1'b1;
			S_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_started_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_started_q <= 1'b1;
					if (clr_started_q && sts.clr_done) state_q <= S_IDLE;
				end
				S_IDLE: if (in_valid) state_q <= S_PSRCH;
				S_PSRCH: begin
					if (sts.is_es) state_q <= S_MREAD;
					else if (sts.prog_done) state_q <= S_PCOMMIT;
				end
				S_PCOMMIT: begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_MREAD: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (sts.map_ok) state_q <= S_ESRCH;
					else begin
						state_q <= S_OUT;
						out_valid <= 1'b1;
					end
				end
				S_ESRCH: if (sts.es_done) state_q <= S_ECOMMIT;
				S_ECOMMIT: begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: if (!out_stall) begin
					state_q <= S_IDLE;
					out_valid <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/tspes_dp.sv
module tspes_dp #(
	parameter int MAX_PROGRAMS = 16,
	parameter int MAX_STREAMS = 16
) (
	input logic clk,
	input logic arst_n,
	input tspes_pkg::cmd_t cmd,
	output tspes_pkg::sts_t sts,
	input logic req_type,
	input logic [15:0] prog_num,
	input logic [15:0] pmt_pid,
	input logic [15:0] es_pid,
	input logic [7:0] strm_type,
	output logic [1:0] status,
	output logic pid_mapped,
	output logic [3:0] program_index,
	output logic [3:0] es_index
);

	localparam int PW = (MAX_PROGRAMS > 1) ? $clog2(MAX_PROGRAMS) : 1;
	localparam int EW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
	localparam int PCW = $clog2(MAX_PROGRAMS + 1);
	localparam int ECW = $clog2(MAX_STREAMS + 1);
	localparam int PB = tspes_pkg::PID_BITS;
	localparam int MW = PW + 1;

	logic [15:0] pnum_store [MAX_PROGRAMS];
	logic [15:0] pmt_store [MAX_PROGRAMS];
	logic [MW-1:0] pid_map [tspes_pkg::PID_SPACE];
	logic [15:0] es_pid_store [MAX_PROGRAMS*MAX_STREAMS];
	logic [7:0] es_type_store [MAX_PROGRAMS*MAX_STREAMS];
	logic [ECW-1:0] es_used_q [MAX_PROGRAMS];
	logic [PCW-1:0] prog_used_q;

	logic req_type_q;
	logic [15:0] pnum_q, pmt_q, epid_q;
	logic [7:0] stype_q;
	logic [PB-1:0] clr_q;
	logic [PCW-1:0] pi_q;
	logic [ECW-1:0] ei_q;
	logic found_q;
	logic [MW-1:0] map_rd_q;
	logic [PW-1:0] slot_q;
	logic [15:0] es_rd_q;
	logic es_rd_v_q;
	logic [ECW-1:0] es_cnt_q;

	logic pmt_in_range;
	logic [PW-1:0] pi_idx;
	logic [EW-1:0] ei_idx;
	logic [PW+EW-1:0] es_addr;
	logic es_hit;

	assign pmt_in_range = (pmt_q[15:PB] == '0);
	assign pi_idx = pi_q[PW-1:0];
	assign ei_idx = ei_q[EW-1:0];
	assign es_addr = {slot_q, ei_idx};
	assign es_hit = es_rd_v_q && (es_rd_q == epid_q);

	always_comb begin
		sts.clr_done = (clr_q == '1);
		sts.is_es = req_type_q;
		sts.prog_done = (pi_q >= prog_used_q) || (pnum_store[pi_idx] == pnum_q);
		sts.map_ok = pmt_in_range && map_rd_q[PW];
		sts.es_done = es_hit || (!es_rd_v_q && ei_q >= es_cnt_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) pid_map[clr_q] <= '0;
		else if (cmd.prog_commit && !(pi_q >= prog_used_q && prog_used_q == PCW'(MAX_PROGRAMS))
				&& pmt_in_range)
			pid_map[pmt_q[PB-1:0]] <= {1'b1, pi_idx};
		if (cmd.map_read) map_rd_q <= pid_map[pmt_q[PB-1:0]];
		if (cmd.es_step) es_rd_q <= es_pid_store[es_addr];
		if (cmd.es_commit && !(ei_q >= es_cnt_q && es_cnt_q == ECW'(MAX_STREAMS))) begin
			es_type_store[es_addr] <= stype_q;
			if (ei_q >= es_cnt_q) es_pid_store[es_addr] <= epid_q;
		end
		if (cmd.prog_commit && pi_q < PCW'(MAX_PROGRAMS)) begin
			pmt_store[pi_idx] <= pmt_q;
			if (pi_q >= prog_used_q) pnum_store[pi_idx] <= pnum_q;
		end
		if (cmd.load) begin
			req_type_q <= req_type;
			pnum_q <= prog_num;
			pmt_q <= pmt_pid;
			epid_q <= es_pid;
			stype_q <= strm_type;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			prog_used_q <= '0;
			for (int i = 0; i < MAX_PROGRAMS; i++) es_used_q[i] <= '0;
			pi_q <= '0;
			ei_q <= '0;
			es_rd_v_q <= 1'b0;
			es_cnt_q <= '0;
			slot_q <= '0;
			status <= '0;
			pid_mapped <= 1'b0;
			program_index <= '0;
			es_index <= '0;
		end else begin
			if (cmd.clr_start) clr_q <= '0;
			else if (cmd.clr_step && clr_q != '1) clr_q <= clr_q + 1'b1;
			if (cmd.load) pi_q <= '0;
			if (cmd.prog_step && !req_type_q && !sts.prog_done) pi_q <= pi_q + 1'b1;
			if (cmd.prog_commit) begin
				if (pi_q >= prog_used_q) begin
					if (prog_used_q == PCW'(MAX_PROGRAMS)) begin
						status <= tspes_pkg::ST_FULL;
						pid_mapped <= 1'b0;
						program_index <= '0;
					end else begin
						status <= tspes_pkg::ST_INSERTED;
						prog_used_q <= prog_used_q + 1'b1;
						pid_mapped <= pmt_in_range;
						program_index <= 4'(pi_q);
					end
				end else begin
					status <= tspes_pkg::ST_UPDATED;
					pid_mapped <= pmt_in_range;
					program_index <= 4'(pi_q);
				end
				es_index <= '0;
			end
			if (cmd.es_start) begin
				slot_q <= map_rd_q[PW-1:0];
				es_cnt_q <= es_used_q[map_rd_q[PW-1:0]];
				ei_q <= '0;
				es_rd_v_q <= 1'b0;
				if (!sts.map_ok) begin
					status <= tspes_pkg::ST_UNMAPPED;
					pid_mapped <= 1'b0;
					program_index <= '0;
					es_index <= '0;
				end
			end
			if (cmd.es_step && !sts.es_done) begin
				if (es_rd_v_q) begin
					ei_q <= ei_q + 1'b1;
					es_rd_v_q <= 1'b0;
				end else begin
					es_rd_v_q <= 1'b1;
				end
			end
			if (cmd.es_commit) begin
				pid_mapped <= 1'b0;
				program_index <= 4'(slot_q);
				if (es_hit) begin
					status <= tspes_pkg::ST_UPDATED;
					es_index <= 4'(ei_q);
				end else if (es_cnt_q == ECW'(MAX_STREAMS)) begin
					status <= tspes_pkg::ST_FULL;
					es_index <= '0;
				end else begin
					status <= tspes_pkg::ST_INSERTED;
					es_index <= 4'(ei_q);
					es_used_q[slot_q] <= es_cnt_q + 1'b1;
				end
			end
		end
	end

endmodule

FILE: tb/ts_program_es_table_core_tb.sv
module ts_program_es_table_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_PROG = 16;
	localparam int N_ES = 16;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct {
		logic req_type;
		logic [15:0] prog_num;
		logic [15:0] pmt_pid;
		logic [15:0] es_pid;
		logic [7:0] strm_type;
	} request_t;

	typedef struct {
		tspes_pkg::status_t status;
		logic pid_mapped;
		logic [3:0] program_index;
		logic [3:0] es_index;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = 1'b0;
	logic [15:0] prog_num = '0;
	logic [15:0] pmt_pid = '0;
	logic [15:0] es_pid = '0;
	logic [7:0] strm_type = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic pid_mapped;
	logic [3:0] program_index;
	logic [3:0] es_index;

	ts_program_es_table_core u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .prog_num(prog_num), .pmt_pid(pmt_pid),
		.es_pid(es_pid), .strm_type(strm_type), .out_valid(out_valid),
		.out_stall(out_stall), .status(status), .pid_mapped(pid_mapped),
		.program_index(program_index), .es_index(es_index)
	);

	// table shadow
	logic [15:0] tbl_prog_num [N_PROG];
	int tbl_prog_cnt;
	logic map_hit [tspes_pkg::PID_SPACE];
	int map_slot [tspes_pkg::PID_SPACE];
	logic [15:0] tbl_es_pid [N_PROG][N_ES];
	int tbl_es_cnt [N_PROG];
	int known_pmt [$];

	request_t pending_reqs [$];
	reply_t expected_replies [$];
	int mismatches = 0;
	int cycles = 0;
	bit stim_done = 0;
	bit hold_sender = 0;

	function automatic reply_t table_update(request_t r);
		reply_t y;
		int slot;
		int e;
		bit hit;
		y = '{tspes_pkg::ST_UNMAPPED, 1'b0, 4'd0, 4'd0};
		hit = 0;
		slot = 0;
		e = 0;
		if (r.req_type == 1'b0) begin
			for (int i = 0; i < tbl_prog_cnt; i++) begin
				if (!hit && tbl_prog_num[i] == r.prog_num) begin
					slot = i;
					hit = 1;
				end
			end
			if (!hit) begin
				if (tbl_prog_cnt >= N_PROG) begin
					y.status = tspes_pkg::ST_FULL;
					return y;
				end
				slot = tbl_prog_cnt++;
				tbl_prog_num[slot] = r.prog_num;
			end
			y.status = hit ? tspes_pkg::ST_UPDATED : tspes_pkg::ST_INSERTED;
			if (r.pmt_pid < tspes_pkg::PID_SPACE) begin
				map_hit[r.pmt_pid] = 1'b1;
				map_slot[r.pmt_pid] = slot;
				y.pid_mapped = 1'b1;
				known_pmt.push_back(r.pmt_pid);
			end
			y.program_index = slot[3:0];
			return y;
		end
		if (r.pmt_pid >= tspes_pkg::PID_SPACE || !map_hit[r.pmt_pid]) return y;
		slot = map_slot[r.pmt_pid];
		y.program_index = slot[3:0];
		for (int i = 0; i < tbl_es_cnt[slot]; i++) begin
			if (!hit && tbl_es_pid[slot][i] == r.es_pid) begin
				e = i;
				hit = 1;
			end
		end
		if (!hit) begin
			if (tbl_es_cnt[slot] >= N_ES) begin
				y.status = tspes_pkg::ST_FULL;
				return y;
			end
			e = tbl_es_cnt[slot]++;
			tbl_es_pid[slot][e] = r.es_pid;
		end
		y.status = hit ? tspes_pkg::ST_UPDATED : tspes_pkg::ST_INSERTED;
		y.es_index = e[3:0];
		return y;
	endfunction

	task automatic add_req(logic t, logic [15:0] pn, logic [15:0] pp, logic [15:0] ep,
			logic [7:0] sty);
		request_t r;
		r = '{t, pn, pp, ep, sty};
		pending_reqs.push_back(r);
	endtask

	function automatic logic [15:0] pick_pmt();
		int k;
		k = $urandom_range(0, 99);
		if (k < 75 && known_pmt.size() > 0)
			return 16'(known_pmt[$urandom_range(0, known_pmt.size() - 1)]);
		if (k < 85) return 16'($urandom_range(8192, 65535));
		return 16'($urandom_range(0, 8191));
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		logic [15:0] pn;
		for (int i = 0; i < tspes_pkg::PID_SPACE; i++) begin
			map_hit[i] = 1'b0;
			map_slot[i] = 0;
		end
		for (int i = 0; i < N_PROG; i++) tbl_es_cnt[i] = 0;
		tbl_prog_cnt = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: unmapped, out of range, extremes, remap
		add_req(1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		add_req(1'b1, 16'h0000, 16'hFFFF, 16'hFFFF, 8'hFF);
		add_req(1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		add_req(1'b0, 16'hFFFF, 16'h1FFF, 16'hFFFF, 8'hFF);
		add_req(1'b0, 16'h1234, 16'h2000, 16'h0000, 8'h00);
		add_req(1'b0, 16'h1234, 16'hFFFF, 16'h0000, 8'h00);
		add_req(1'b1, 16'hFFFF, 16'h2000, 16'h0001, 8'h02);
		add_req(1'b1, 16'h5555, 16'h0000, 16'h0000, 8'h00);
		add_req(1'b1, 16'hAAAA, 16'h0000, 16'h0000, 8'hFF);
		add_req(1'b1, 16'h0000, 16'h1FFF, 16'hFFFF, 8'hAA);
		add_req(1'b1, 16'h0000, 16'h1FFF, 16'hFFFF, 8'h55);
		add_req(1'b0, 16'hFFFF, 16'h0000, 16'h0000, 8'h00);
		add_req(1'b1, 16'h0000, 16'h0000, 16'h0100, 8'h1B);
		// ES list full on slot behind PID 0x1FFF
		for (int i = 0; i < 16; i++) add_req(1'b1, 16'h0, 16'h1FFF, 16'(16'h100 + i), 8'h0F);

		// random: fill programs/streams with mostly well-formed traffic
		for (int n = 0; n < 1350; n++) begin
			if (n == 600) begin
				wait (pending_reqs.size() == 0);
				hold_sender = 1;
				wait (expected_replies.size() == 0);
				hold_sender = 0;
			end
			if ($urandom_range(0, 99) < 30) begin
				pn = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
				add_req(1'b0, pn, ($urandom_range(0, 9) == 0) ? 16'($urandom) :
					16'($urandom_range(0, 63)), 16'($urandom), 8'($urandom));
			end else begin
				add_req(1'b1, 16'($urandom), pick_pmt(),
					($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20)),
					8'($urandom));
			end
		end
		wait (pending_reqs.size() == 0);
		stim_done = 1;
	end

	// driver
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_replies.push_back(table_update(pending_reqs.pop_front()));
				send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
			end
			if (in_valid && in_stall) begin
			end else if (send_gap > 0) begin
				send_gap = send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0 && !hold_sender) begin
				in_valid <= 1'b1;
				req_type <= pending_reqs[0].req_type;
				prog_num <= pending_reqs[0].prog_num;
				pmt_pid <= pending_reqs[0].pmt_pid;
				es_pid <= pending_reqs[0].es_pid;
				strm_type <= pending_reqs[0].strm_type;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	int recv_gap = 0;
	always @(posedge clk) begin
		reply_t x;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected transfer: status %0d", status);
				end else begin
					x = expected_replies.pop_front();
					if (status !== x.status || pid_mapped !== x.pid_mapped ||
							program_index !== x.program_index || es_index !== x.es_index) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp st=%0d map=%0d pi=%0d ei=%0d got st=%0d map=%0d pi=%0d ei=%0d",
								x.status, x.pid_mapped, x.program_index, x.es_index,
								status, pid_mapped, program_index, es_index);
					end
				end
				recv_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
			end
			if (recv_gap > 0) begin
				recv_gap = recv_gap - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		wait (expected_replies.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_replies.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
